// ===== src/rrt_pkg.sv =====
`default_nettype none

package rrt_pkg;

  localparam int unsigned SOURCES    = 256;
  localparam int unsigned TIME_BITS  = 32;
  localparam int unsigned IDX_BITS   = (SOURCES > 1) ? $clog2(SOURCES) : 1;
  localparam int unsigned SRC_BITS   = 8;
  localparam int unsigned NOW_BITS   = 32;
  localparam int unsigned COUNT_BITS = 32;
  localparam int unsigned GAP_BITS   = 16;
  localparam int unsigned CFG_BITS   = 16;
  localparam int unsigned CFG_IDX_BITS = 4;

  localparam logic [CFG_BITS-1:0] LIMIT_RESET   = CFG_BITS'(20);
  localparam logic [CFG_BITS-1:0] MAX_GAP_RESET = CFG_BITS'(60 * 5);
  localparam logic [GAP_BITS-1:0] GAP_RESET     = GAP_BITS'(2);

  localparam logic [CFG_IDX_BITS-1:0] REG_LIMIT   = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_GAP = CFG_IDX_BITS'(1);

  typedef enum logic [1:0] {
    KIND_SUPPRESSED = 2'd0,
    KIND_BELOW      = 2'd1,
    KIND_FINAL      = 2'd2,
    KIND_THROTTLED  = 2'd3
  } kind_e;

  typedef struct packed {
    logic [COUNT_BITS-1:0] count;
    logic [TIME_BITS-1:0]  last;
    logic [GAP_BITS-1:0]   gap;
  } entry_t;

  localparam int unsigned ENTRY_BITS = $bits(entry_t);

  localparam entry_t ENTRY_RESET = '{
    count: '0,
    last:  '0,
    gap:   GAP_RESET
  };

endpackage

`default_nettype wire

// ===== src/repeat_report_throttle.sv =====
`default_nettype none

// the result strobe done_o is registered from s1_valid_q, which registers each start transfer
// throughput: one event per cycle, one read and one write of the source table ram;
// a write forwarding register covers back-to-back events on the same source
// reset: per-entry valid bits clear at once, so every entry reads as count 0,
// last report time 0 and gap 2; limit returns to 20 and max gap to 300
// results cannot be stalled, busy stays low
module repeat_report_throttle (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [rrt_pkg::SRC_BITS-1:0]        source_index_i,
  input  wire logic [rrt_pkg::NOW_BITS-1:0]        now_seconds_i,
  input  wire logic                                cfg_we_i,
  input  wire logic [rrt_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  wire logic [rrt_pkg::CFG_BITS-1:0]        cfg_wdata_i,
  output logic                                     done_o,
  output logic [1:0]                               report_kind_o,
  output logic [rrt_pkg::COUNT_BITS-1:0]           occurrence_count_o
);

  import rrt_pkg::*;

  logic [CFG_BITS-1:0]   limit_q;
  logic [CFG_BITS-1:0]   max_gap_q;
  logic [SOURCES-1:0]    vld_q;

  logic                  accept;
  logic                  src_ok;
  logic [IDX_BITS-1:0]   rd_addr;

  logic                  s1_valid_q;
  logic                  s1_src_ok_q;
  logic                  s1_vld_q;
  logic [IDX_BITS-1:0]   s1_addr_q;
  logic [TIME_BITS-1:0]  s1_now_q;

  logic                  fwd_valid_q;
  logic [IDX_BITS-1:0]   fwd_addr_q;
  entry_t                fwd_data_q;

  logic [ENTRY_BITS-1:0] ram_rdata;
  entry_t                cur;
  entry_t                upd;
  logic                  wr_en;
  logic [COUNT_BITS-1:0] cnt;
  logic [COUNT_BITS-1:0] limit_ext;
  logic [TIME_BITS-1:0]  elapsed;
  logic [GAP_BITS:0]     grown;
  kind_e                 kind;

  logic                  done_q;
  kind_e                 kind_q;
  logic [COUNT_BITS-1:0] count_q;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign src_ok  = 32'(source_index_i) < 32'(SOURCES);
  assign rd_addr = IDX_BITS'(source_index_i);

  rrt_ram #(
    .WIDTH(ENTRY_BITS),
    .DEPTH(SOURCES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(s1_addr_q),
    .wdata_i(upd),
    .re_i   (accept),
    .raddr_i(rd_addr),
    .rdata_o(ram_rdata)
  );

  // newest entry value: last write, then stored data, then reset value
  always_comb begin
    priority if (fwd_valid_q && fwd_addr_q == s1_addr_q) begin
      cur = fwd_data_q;
    end else if (s1_vld_q) begin
      cur = entry_t'(ram_rdata);
    end else begin
      cur = ENTRY_RESET;
    end
  end

  always_comb begin
    cnt       = (cur.count == '1) ? cur.count : cur.count + COUNT_BITS'(1);
    limit_ext = COUNT_BITS'(limit_q);
    elapsed   = s1_now_q - cur.last;
    grown     = {1'b0, cur.gap} + {2'b00, cur.gap[GAP_BITS-1:1]};
    upd       = cur;
    upd.count = cnt;
    kind      = KIND_SUPPRESSED;
    priority if (cnt < limit_ext) begin
      kind     = KIND_BELOW;
      upd.last = s1_now_q;
    end else if (cnt == limit_ext) begin
      kind     = KIND_FINAL;
      upd.last = s1_now_q;
    end else if (elapsed >= TIME_BITS'(cur.gap)) begin
      kind     = KIND_THROTTLED;
      upd.last = s1_now_q;
      upd.gap  = (grown > {1'b0, max_gap_q}) ? max_gap_q : grown[GAP_BITS-1:0];
    end
  end

  assign wr_en = s1_valid_q && s1_src_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q   <= LIMIT_RESET;
      max_gap_q <= MAX_GAP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LIMIT:   limit_q   <= cfg_wdata_i;
        REG_MAX_GAP: max_gap_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      s1_valid_q  <= accept;
      fwd_valid_q <= wr_en;
      done_q      <= s1_valid_q;
      if (wr_en) begin
        vld_q[s1_addr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_src_ok_q <= src_ok;
      s1_vld_q    <= src_ok && vld_q[rd_addr];
      s1_addr_q   <= rd_addr;
      s1_now_q    <= TIME_BITS'(now_seconds_i);
    end
    if (wr_en) begin
      fwd_addr_q <= s1_addr_q;
      fwd_data_q <= upd;
    end
    if (s1_valid_q) begin
      kind_q  <= s1_src_ok_q ? kind : KIND_SUPPRESSED;
      count_q <= s1_src_ok_q ? cnt : '0;
    end
  end

  assign done_o             = done_q;
  assign report_kind_o      = kind_q;
  assign occurrence_count_o = count_q;

`ifndef SYNTH
  a_done_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##2 done_o)
    else $error("missing result after start transfer");

  a_done_has_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 2))
    else $error("result without start transfer");

  a_final_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && report_kind_o == KIND_FINAL |-> occurrence_count_o == COUNT_BITS'(limit_q))
    else $error("final warning away from limit");

  a_below_under_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && report_kind_o == KIND_BELOW |-> occurrence_count_o < COUNT_BITS'(limit_q))
    else $error("below-limit report at or over limit");
`endif

endmodule

`default_nettype wire

// ===== src/rrt_ram.sv =====
`default_nettype none

module rrt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             we_i,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  wire logic [WIDTH-1:0]                 wdata_i,
  input  wire logic                             re_i,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic      [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import rrt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASES = 8;
  localparam int unsigned PHASE_EVENTS = 130;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned MAX_SHOWN = 10;
  localparam int unsigned POOL_SIZE = 3;
  localparam logic [CFG_IDX_BITS-1:0] REG_IDX_TOP = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_SAT = '1;

  typedef struct packed {
    kind_e                 kind;
    logic [COUNT_BITS-1:0] count;
  } report_t;

  class throttle_scoreboard;
    logic [CFG_BITS-1:0]   limit_r;
    logic [CFG_BITS-1:0]   max_gap_r;
    logic [COUNT_BITS-1:0] count_tbl [SOURCES];
    logic [TIME_BITS-1:0]  last_tbl [SOURCES];
    logic [GAP_BITS-1:0]   gap_tbl [SOURCES];
    report_t               reports_q [$];
    int unsigned           errors;
    int unsigned           checked;
    int unsigned           kind_hits [4];

    function new();
      limit_r = LIMIT_RESET;
      max_gap_r = MAX_GAP_RESET;
      foreach (count_tbl[i]) begin
        count_tbl[i] = '0;
        last_tbl[i] = '0;
        gap_tbl[i] = GAP_RESET;
      end
    endfunction

    function int unsigned pending();
      return reports_q.size();
    endfunction

    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
      if (idx == REG_LIMIT) begin
        limit_r = data;
      end else if (idx == REG_MAX_GAP) begin
        max_gap_r = data;
      end
    endfunction

    function void note_event(logic [SRC_BITS-1:0] src, logic [NOW_BITS-1:0] now);
      logic [COUNT_BITS-1:0] cnt;
      logic [TIME_BITS-1:0]  stamp;
      logic [TIME_BITS-1:0]  elapsed;
      logic [GAP_BITS:0]     grown;
      report_t               rep;
      stamp = now[TIME_BITS-1:0];
      cnt = count_tbl[src];
      if (cnt != COUNT_SAT) cnt = cnt + 1'b1;
      count_tbl[src] = cnt;
      rep.count = cnt;
      rep.kind = KIND_SUPPRESSED;
      if (cnt < COUNT_BITS'(limit_r)) begin
        rep.kind = KIND_BELOW;
        last_tbl[src] = stamp;
      end else if (cnt == COUNT_BITS'(limit_r)) begin
        rep.kind = KIND_FINAL;
        last_tbl[src] = stamp;
      end else begin
        elapsed = stamp - last_tbl[src];
        if (elapsed >= TIME_BITS'(gap_tbl[src])) begin
          rep.kind = KIND_THROTTLED;
          last_tbl[src] = stamp;
          // grow by half at full width, then cap
          grown = {1'b0, gap_tbl[src]} + (gap_tbl[src] >> 1);
          if (grown > {1'b0, max_gap_r}) grown = {1'b0, max_gap_r};
          gap_tbl[src] = grown[GAP_BITS-1:0];
        end
      end
      reports_q.push_back(rep);
    endfunction

    function void flag(string what, longint unsigned want, longint unsigned got);
      errors++;
      if (errors <= MAX_SHOWN) begin
        $display("[%0t] %s mismatch: expected %0d, got %0d", $time, what, want, got);
      end
    endfunction

    function void check_report(logic [1:0] kind, logic [COUNT_BITS-1:0] count);
      report_t want;
      checked++;
      if (reports_q.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN) begin
          $display("[%0t] report with nothing pending: kind %0d count %0d", $time, kind, count);
        end
        return;
      end
      want = reports_q.pop_front();
      kind_hits[want.kind]++;
      if (kind !== want.kind) flag("report_kind", want.kind, kind);
      if (count !== want.count) flag("occurrence_count", want.count, count);
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic [SRC_BITS-1:0]     source_index_i;
  logic [NOW_BITS-1:0]     now_seconds_i;
  logic                    cfg_we_i;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i;
  logic [CFG_BITS-1:0]     cfg_wdata_i;
  logic                    done_o;
  logic [1:0]              report_kind_o;
  logic [COUNT_BITS-1:0]   occurrence_count_o;

  throttle_scoreboard sb = new();
  int unsigned events_sent;
  int unsigned settings_used;
  int unsigned cycles;

  repeat_report_throttle dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .source_index_i     (source_index_i),
    .now_seconds_i      (now_seconds_i),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .done_o             (done_o),
    .report_kind_o      (report_kind_o),
    .occurrence_count_o (occurrence_count_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_report(report_kind_o, occurrence_count_o);
  end

  task automatic send_event(logic [SRC_BITS-1:0] src, logic [NOW_BITS-1:0] now);
    start <= 1'b1;
    source_index_i <= src;
    now_seconds_i <= now;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_event(src, now);
    events_sent++;
  endtask

  task automatic pause_sender(int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic random_pause();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r >= 92) begin
      pause_sender($urandom_range(8, 40));
    end else if (r >= 70) begin
      pause_sender($urandom_range(1, 3));
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, data);
    @(posedge clk_i);
  endtask

  task automatic set_config(logic [CFG_BITS-1:0] limit, logic [CFG_BITS-1:0] gap_cap);
    // unlisted index must be ignored
    write_reg(CFG_IDX_BITS'($urandom_range(REG_MAX_GAP + 1, REG_IDX_TOP)),
              CFG_BITS'($urandom));
    write_reg(REG_LIMIT, limit);
    write_reg(REG_MAX_GAP, gap_cap);
    settings_used++;
  endtask

  task automatic run_phase(int unsigned events, logic [NOW_BITS-1:0] t0, bit mid_drain);
    logic [SRC_BITS-1:0] pool [POOL_SIZE];
    logic [NOW_BITS-1:0] clock_s;
    int unsigned         r;
    foreach (pool[i]) pool[i] = SRC_BITS'($urandom_range(0, SOURCES - 1));
    clock_s = t0;
    for (int unsigned n = 0; n < events; n++) begin
      r = $urandom_range(0, 99);
      if (r < 85) begin
        r = $urandom_range(0, 99);
        if (r < 75) begin
          clock_s += $urandom_range(0, 3);
        end else if (r < 95) begin
          clock_s += $urandom_range(4, 400);
        end else begin
          clock_s += $urandom_range(1000, 70000);
        end
        send_event(pool[$urandom_range(0, POOL_SIZE - 1)], clock_s);
      end else begin
        send_event(SRC_BITS'($urandom), $urandom);
      end
      if (mid_drain && n == events / 2) begin
        drain();
      end else begin
        random_pause();
      end
    end
  endtask

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("run stopped after %0d cycles with %0d reports pending", cycles, sb.pending());
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    logic [NOW_BITS-1:0] t0;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    start = 1'b0;
    source_index_i = '0;
    now_seconds_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    events_sent = 0;
    settings_used = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // limit 2, cap 3: every kind, gap growth and cap, time wrap
    set_config(2, 3);
    send_event(8'h00, 32'd0);
    send_event(8'h00, 32'd100);
    send_event(8'h00, 32'd101);
    send_event(8'h00, 32'd102);
    send_event(8'h00, 32'd104);
    send_event(8'h00, 32'd105);
    send_event(8'hFF, 32'hFFFF_FFFF);
    send_event(8'hFF, 32'hFFFF_FFFE);
    send_event(8'hFF, 32'h0000_0000);
    send_event(8'hFF, 32'hFFFF_FFFF);
    send_event(8'hFF, 32'h0000_0001);
    send_event(8'hFF, 32'h0000_0002);
    drain();

    // zero limit gives no below-limit or final report: every event is throttled or suppressed
    set_config(0, 3);
    send_event(8'h55, 32'd0);
    send_event(8'h55, 32'd2);
    send_event(8'hAA, 32'h5555_5555);
    drain();

    set_config(16'hFFFF, 16'hFFFF);
    send_event(8'h01, 32'hAAAA_AAAA);
    send_event(8'h01, 32'hAAAA_AAAA);

    for (int unsigned p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: set_config(LIMIT_RESET, MAX_GAP_RESET);
        1: set_config(1, 2);
        2: set_config(3, 16'hFFFF);
        3: set_config(0, 5);
        4: set_config(5, 12);
        5: set_config(20, 2);
        6: set_config(CFG_BITS'($urandom_range(1, 12)), CFG_BITS'($urandom_range(2, 50)));
        default: set_config(CFG_BITS'($urandom), CFG_BITS'($urandom));
      endcase
      t0 = (p == 3) ? 32'hFFFF_FF00 : $urandom;
      run_phase(PHASE_EVENTS, t0, p == 2);
    end
    drain();

    $display("%0d events under %0d register settings, %0d reports checked",
             events_sent, settings_used, sb.checked);
    $display("kinds seen: below %0d, final %0d, throttled %0d, suppressed %0d",
             sb.kind_hits[KIND_BELOW], sb.kind_hits[KIND_FINAL],
             sb.kind_hits[KIND_THROTTLED], sb.kind_hits[KIND_SUPPRESSED]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
